>>> sv/frps_pkg.sv
// ----------------------------------------------------------------------------
// frps_pkg
// Types and constants shared by the fixed-radius pair search block.
// ----------------------------------------------------------------------------
package frps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int IDX_W          = 6;
  localparam int COORD_W        = 16;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  // register indexes (paddr[2] selects the word)
  localparam logic REG_RADIUS = 1'b0;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             last_pair;
  } pair_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

>>> sv/frps_ram.sv
// ----------------------------------------------------------------------------
// frps_ram
// Generic single-write, single-read RAM with registered read and read enable.
// ----------------------------------------------------------------------------
module frps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/fixed_radius_pair_search.sv
// ----------------------------------------------------------------------------
// fixed_radius_pair_search
// Brute-force 2-D neighbour pair search over a stored point set.
// ----------------------------------------------------------------------------
// Points come in on the point channel (valid/stall), signed Q8.8. kind 0
// opens a new set, kind 1 adds to the current one. Each point is written to
// the coordinate RAM at its index when its beat is taken, then the earlier
// points are read back one per cycle while the output does not stall, and
// every pair with squared distance strictly below radius squared leaves on
// the pair channel, in ascending order of the earlier index, last_pair
// marking the final one. A point with earlier points holds the input until
// all of them have gone through the three-stage distance pipeline and the
// scan has closed, so no new point is taken during a scan. Each pair waits
// in the scan for the next match or the end of the scan before it is
// registered on the output. A point with no earlier points, or one arriving
// when the set is full, starts no scan and gives nothing. The radius
// register (APB, byte address 0) is squared in a register every cycle. When
// the receiver stalls, the whole scan pipeline freezes until the output
// register empties. Reset empties the set, clears the radius and drops any
// pending pair; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module fixed_radius_pair_search
  import frps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_t                point,
  output logic                  pair_valid,
  input  logic                  pair_stall,
  output pair_t                 pair,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = 2 * COORD_W;

  // configuration
  logic [COORD_W-1:0] radius;
  logic [RW-1:0]      r2;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? APB_DATA_W'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
      radius <= pwdata[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    r2 <= RW'(radius) * RW'(radius);
  end

  // control state
  state_t state, state_next;
  logic [CW-1:0]      count;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      last_addr;
  logic               issue_done;
  logic [IDX_W-1:0]   cur_index;
  logic [COORD_W-1:0] nx, ny;

  logic          accept;
  logic [CW-1:0] count_eff;
  logic          full;
  logic          store;
  logic          go_scan;
  logic          en;
  logic          issue;
  logic          drained;

  // pipeline
  logic                      v1, v2, v3;
  logic [AW-1:0]             idx1, idx2, idx3;
  logic [RW-1:0]             rdata;
  logic signed [COORD_W:0]   dx, dy;
  logic [RW-1:0]             sqx, sqy;
  logic [RW:0]               dist2;
  logic                      match;

  logic             pend_valid;
  logic [AW-1:0]    pend_idx;
  logic             load;
  pair_t            load_data;

  assign accept    = point_valid && !point_stall;
  assign count_eff = point.kind ? count : '0;
  assign full      = (count_eff >= CW'(MAX_POINTS));
  assign store     = accept && !full;
  assign go_scan   = store && (count_eff != '0);
  assign en        = !pair_valid || !pair_stall;
  assign drained   = issue_done && !v1 && !v2 && !v3;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go_scan) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (drained && en) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    point_stall = 1'b1;
    issue       = 1'b0;
    case (state)
      ST_IDLE: point_stall = 1'b0;
      ST_SCAN: issue = en && !issue_done;
      default: point_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // the new point goes to its own index; this scan only reads lower ones
  frps_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_coord_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count_eff[AW-1:0]),
    .wdata ({point.x_pos, point.y_pos}),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      issue_done <= 1'b1;
      rd_addr    <= '0;
    end else begin
      if (store) begin
        count <= count_eff + 1'b1;
      end
      if (go_scan) begin
        issue_done <= 1'b0;
        rd_addr    <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + 1'b1;
        if (rd_addr == last_addr) issue_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_scan) begin
      last_addr <= AW'(count_eff - 1'b1);
      cur_index <= IDX_W'(count_eff);
      nx        <= point.x_pos;
      ny        <= point.y_pos;
    end
  end

  // distance pipeline: read, difference, squares, sum and compare
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= rd_addr;
      idx2 <= idx1;
      idx3 <= idx2;
      dx   <= (COORD_W+1)'($signed(rdata[RW-1:COORD_W])) - (COORD_W+1)'($signed(nx));
      dy   <= (COORD_W+1)'($signed(rdata[COORD_W-1:0])) - (COORD_W+1)'($signed(ny));
      // squares of 17-bit differences stay below 2^32
      sqx  <= RW'(dx) * RW'(dx);
      sqy  <= RW'(dy) * RW'(dy);
    end
  end

  assign dist2 = (RW+1)'(sqx) + (RW+1)'(sqy);
  assign match = v3 && (dist2 < (RW+1)'(r2));

  // one pair is held back until the next match or the end of the scan
  always_comb begin
    load      = 1'b0;
    load_data = '0;
    if (en) begin
      if (match && pend_valid) begin
        load      = 1'b1;
        load_data = '{first_index: IDX_W'(pend_idx), second_index: cur_index,
                      last_pair: 1'b0};
      end else if (state == ST_SCAN && drained && pend_valid) begin
        load      = 1'b1;
        load_data = '{first_index: IDX_W'(pend_idx), second_index: cur_index,
                      last_pair: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (en) begin
      if (match) begin
        pend_valid <= 1'b1;
      end else if (state == ST_SCAN && drained) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && match) begin
      pend_idx <= idx3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (load) begin
      pair_valid <= 1'b1;
    end else if (!pair_stall) begin
      pair_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair <= load_data;
    end
  end

endmodule

>>> sim/frps_checker.sv
// ----------------------------------------------------------------------------
// frps_checker
// Scoreboard for the fixed-radius pair search: watches the point, pair and
// APB traffic and compares every pair beat with the next one predicted.
// ----------------------------------------------------------------------------
// Keeps its own copy of the point set and of the radius. Each accepted point
// beat is scanned against the earlier points of its set, and the pairs it
// must cause are queued in order. Each accepted pair beat is checked against
// the head of that queue. Register reads are checked against the radius copy.
// ----------------------------------------------------------------------------
module frps_checker
  import frps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  input  logic                  point_stall,
  input  point_t                point,
  input  logic                  pair_valid,
  input  logic                  pair_stall,
  input  pair_t                 pair,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    pairs_waiting
);

  localparam int CAPACITY = (MAX_POINTS > 64) ? 64 : MAX_POINTS;

  logic signed [COORD_W-1:0] x_seen [64];
  logic signed [COORD_W-1:0] y_seen [64];
  int                        set_size;
  logic [15:0]               radius_q;
  pair_t                     pairs_due [$];

  // queue the pairs a new point makes with the earlier points of its set
  task automatic find_neighbours(input point_t p);
    longint dx, dy, dist2, r2;
    int     idx;
    pair_t  held;
    logic   have_held;
    if (!p.kind) set_size = 0;
    if (set_size >= CAPACITY) return;
    idx       = set_size;
    have_held = 1'b0;
    held      = '0;
    r2        = longint'(radius_q) * longint'(radius_q);
    for (int a = 0; a < idx; a++) begin
      dx    = longint'($signed(x_seen[a])) - longint'($signed(p.x_pos));
      dy    = longint'($signed(y_seen[a])) - longint'($signed(p.y_pos));
      dist2 = dx * dx + dy * dy;
      if (dist2 < r2) begin
        if (have_held) pairs_due.push_back(held);
        held.first_index  = a[IDX_W-1:0];
        held.second_index = idx[IDX_W-1:0];
        held.last_pair    = 1'b0;
        have_held         = 1'b1;
      end
    end
    if (have_held) begin
      held.last_pair = 1'b1;
      pairs_due.push_back(held);
    end
    x_seen[idx] = p.x_pos;
    y_seen[idx] = p.y_pos;
    set_size    = set_size + 1;
  endtask

  always @(posedge clk) begin : watch
    pair_t want;
    if (rst) begin
      set_size = 0;
      radius_q = '0;
      pairs_due.delete();
      mismatches    = 0;
      pairs_waiting = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == REG_RADIUS) begin
        if (pwrite) begin
          radius_q = pwdata[15:0];
        end else if (prdata[15:0] !== radius_q) begin
          if (mismatches < 10)
            $display("radius readback: expected %h, got %h", radius_q, prdata[15:0]);
          mismatches++;
        end
      end
      if (pair_valid && !pair_stall) begin
        if (pairs_due.size() == 0) begin
          if (mismatches < 10)
            $display("pair beat: expected none, got %0d/%0d/%b",
                     pair.first_index, pair.second_index, pair.last_pair);
          mismatches++;
        end else begin
          want = pairs_due.pop_front();
          if (pair.first_index !== want.first_index ||
              pair.second_index !== want.second_index ||
              pair.last_pair !== want.last_pair) begin
            if (mismatches < 10)
              $display("pair mismatch: expected %0d/%0d/%b, got %0d/%0d/%b",
                       want.first_index, want.second_index, want.last_pair,
                       pair.first_index, pair.second_index, pair.last_pair);
            mismatches++;
          end
        end
      end
      if (point_valid && !point_stall) find_neighbours(point);
      pairs_waiting = pairs_due.size();
    end
  end

endmodule

>>> sim/fixed_radius_pair_search_tb.sv
// ----------------------------------------------------------------------------
// fixed_radius_pair_search_tb
// Stimulus and verdict for the fixed-radius pair search block.
// ----------------------------------------------------------------------------
// A directed opening covers coordinate extremes, zero and full radius, the
// exact-radius boundary and points sent before any set was opened. Random
// phases then set a fresh radius over APB and send clustered point sets,
// with one phase filling the set past capacity while the pair side holds
// off for a long stretch. Checking is done by frps_checker.
// ----------------------------------------------------------------------------
module fixed_radius_pair_search_tb;
  import frps_pkg::*;

  localparam int MAX_POINTS  = MAX_POINTS_DEF;
  localparam int SCAN_CYCLES = MAX_POINTS + 16;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 3000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  point_valid;
  logic                  point_stall;
  point_t                point;
  logic                  pair_valid;
  logic                  pair_stall;
  pair_t                 pair;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int   mismatches;
  int   pairs_waiting;
  int   cycle_count = 0;
  logic send_calm   = 1'b0;
  logic recv_calm   = 1'b0;
  logic press_on    = 1'b0;

  fixed_radius_pair_search #(.MAX_POINTS(MAX_POINTS)) u_top (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frps_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .pairs_waiting(pairs_waiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic point_t mk_point(input logic kind, input logic [15:0] x,
                                      input logic [15:0] y);
    point_t p;
    p.kind  = kind;
    p.x_pos = x;
    p.y_pos = y;
    return p;
  endfunction

  function automatic logic [15:0] near(input logic [15:0] c, input int spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    return 16'(int'($signed(c)) + off);
  endfunction

  // pair side: random stall runs, plus one long hold-off when asked
  initial begin : pair_side
    int n;
    logic held;
    pair_stall = 1'b0;
    held       = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (press_on && !held) begin
        held       = 1'b1;
        pair_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      n = pick_gap(recv_calm);
      if (n > 0) begin
        pair_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      pair_stall = 1'b0;
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_point(input point_t p);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      point_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_valid = 1'b1;
    point       = p;
    @(posedge clk);
    while (!(point_valid && !point_stall)) @(posedge clk);
    @(negedge clk);
  endtask

  // let every pair drain, then cover a scan that makes no pair
  task automatic settle();
    point_valid = 1'b0;
    while (pairs_waiting != 0) @(negedge clk);
    repeat (SCAN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [15:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {REG_RADIUS, 2'b00};
    pwdata  = {16'h0000, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_radius(input logic [15:0] value);
    settle();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
  endtask

  task automatic random_phase(input int n_items);
    logic [15:0] rad;
    logic [15:0] cx, cy, px, py;
    int          spread, set_left, r;
    r = $urandom_range(0, 99);
    if (r < 8)       rad = 16'h0000;
    else if (r < 16) rad = 16'hFFFF;
    else if (r < 60) rad = 16'($urandom_range(16'h0040, 16'h0800));
    else             rad = 16'($urandom_range(16'h0800, 16'h8000));
    if (rad == 0)              spread = 256;
    else if (rad == 16'hFFFF)  spread = 20000;
    else                       spread = (int'(rad) * 2 > 30000) ? 30000 : int'(rad) * 2;
    set_radius(rad);
    send_calm = ($urandom_range(0, 3) == 0);
    recv_calm = ($urandom_range(0, 3) == 0);
    set_left  = 0;
    cx        = '0;
    cy        = '0;
    for (int i = 0; i < n_items; i++) begin
      // occasionally break a set early with a fresh kind 0
      if (set_left == 0 || $urandom_range(0, 19) == 0) begin
        set_left = $urandom_range(1, 12);
        cx       = 16'($urandom);
        cy       = 16'($urandom);
        r        = 0;
      end else begin
        r = 1;
      end
      set_left--;
      if ($urandom_range(0, 9) == 0) begin
        px = 16'($urandom);
        py = 16'($urandom);
      end else begin
        px = near(cx, spread);
        py = near(cy, spread);
      end
      send_point(mk_point(r[0], px, py));
    end
  endtask

  // fills a set past capacity while the pair side is held off
  task automatic capacity_phase();
    logic [15:0] cx, cy;
    set_radius(16'h0200);
    send_calm = 1'b1;
    recv_calm = 1'b0;
    press_on  = 1'b1;
    cx        = 16'($urandom);
    cy        = 16'($urandom);
    for (int i = 0; i < MAX_POINTS + 4; i++)
      send_point(mk_point(i != 0, near(cx, 16'h0600), near(cy, 16'h0600)));
    for (int i = 0; i < 3; i++)
      send_point(mk_point(i != 0, near(cx, 16'h0300), near(cy, 16'h0300)));
  endtask

  initial begin : stimulus
    int done_items, n;
    point_valid = 1'b0;
    point       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // radius still at its reset value; kind 1 with no set opened
    send_point(mk_point(1'b1, 16'h0000, 16'h0000));
    send_point(mk_point(1'b1, 16'h0000, 16'h0000));
    send_point(mk_point(1'b0, 16'h7FFF, 16'h7FFF));
    send_point(mk_point(1'b1, 16'h8000, 16'h8000));

    // full radius against the coordinate corners
    set_radius(16'hFFFF);
    send_point(mk_point(1'b0, 16'h8000, 16'h8000));
    send_point(mk_point(1'b1, 16'h7FFF, 16'h7FFF));
    send_point(mk_point(1'b1, 16'h8000, 16'h7FFF));
    send_point(mk_point(1'b1, 16'h0000, 16'h0000));
    send_point(mk_point(1'b1, 16'h5555, 16'hAAAA));

    // one unit radius: distance exactly equal to it is not a pair
    set_radius(16'h0100);
    send_point(mk_point(1'b0, 16'h0000, 16'h0000));
    send_point(mk_point(1'b1, 16'h0100, 16'h0000));
    send_point(mk_point(1'b1, 16'h00FF, 16'h0000));
    send_point(mk_point(1'b1, 16'h0000, 16'hFF00));
    send_point(mk_point(1'b1, 16'h0080, 16'h0080));
    send_point(mk_point(1'b1, 16'h0001, 16'hFFFF));

    set_radius(16'h0000);
    send_point(mk_point(1'b0, 16'h1234, 16'h1234));
    send_point(mk_point(1'b1, 16'h1234, 16'h1234));

    // directed opening above
    done_items = 17;
    random_phase(12);
    done_items += 12;
    capacity_phase();
    done_items += MAX_POINTS + 7;
    while (done_items < 100) begin
      n = $urandom_range(8, 20);
      random_phase(n);
      done_items += n;
    end

    send_calm = 1'b0;
    settle();
    if (mismatches == 0 && pairs_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
